/* design/rmts_pkg.sv */
package rmts_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_BITS     = 16;
    localparam int WAIT_BITS     = 16;

    localparam logic       CMD_LOAD = 1'b0;
    localparam logic       CMD_TICK = 1'b1;
    localparam logic       CFG_TASK_COUNT = 1'b0;
    localparam logic       CFG_SCHED_LEN  = 1'b1;
    localparam logic [3:0] TASK_COUNT_RST = 4'd8;
    localparam logic [15:0] SCHED_LEN_RST = 16'hFFFF;

    typedef logic [TIME_BITS-1:0] t_time;

    // one task table entry; flags = {predecessor_mask, preemptible}
    typedef struct packed {
        t_time      next_release;
        t_time      exec;
        t_time      period;
        logic [8:0] flags;
        t_time      deadline;
        t_time      job_release;
        t_time      remaining;
    } t_entry;

    typedef struct packed {
        logic       cmd;
        logic [2:0] task_index;
        t_time      release_time;
        t_time      exec_time;
        t_time      period;
        t_time      initial_deadline;
        logic       preemptible;
        logic [7:0] predecessor_mask;
    } t_item;

    typedef struct packed {
        logic                 busy_res;
        logic [2:0]           running_task;
        logic                 job_done;
        logic                 deadline_met;
        logic [WAIT_BITS-1:0] waiting_time;
        logic                 overrun;
        logic                 past_end;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_SEL,
        S_RUN_RD,
        S_RUN,
        S_OUT
    } t_state;

endpackage

/* design/rate_monotonic_tick_scheduler_unit.sv */
// Rate-monotonic tick scheduler, task table in one synchronous memory.
// Load transaction: accepted in S_IDLE and written to the table, no result. Past-end
//   tick: result via S_OUT. Tick transaction: a release pass over the N tasks in use,
//   a selection pass unless a non-preemptible job keeps running, then read, run and
//   output states. One transaction at a time; next accepted once the result is pushed.
// Reset (synchronous, active low) clears time, masks and control; no table reset.
module rate_monotonic_tick_scheduler_unit
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [2:0]  i_task_index,
    input  logic [15:0] i_release_time,
    input  logic [15:0] i_exec_time,
    input  logic [15:0] i_period,
    input  logic [15:0] i_initial_deadline,
    input  logic        i_preemptible,
    input  logic [7:0]  i_predecessor_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_busy_res,
    output logic [2:0]  o_running_task,
    output logic        o_job_done,
    output logic        o_deadline_met,
    output logic [15:0] o_waiting_time,
    output logic        o_overrun,
    output logic        o_past_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [3:0]       r_task_count;
    logic [15:0]      r_sched_len;
    logic [CNT_W-1:0] count;
    logic             r_out_valid;
    t_result          r_out;
    t_item            item;
    t_result          res;
    logic             push;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    t_entry           wdata;
    t_entry           rdata;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
            r_sched_len  <= SCHED_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TASK_COUNT: r_task_count <= i_cfg_data[3:0];
                CFG_SCHED_LEN:  r_sched_len  <= i_cfg_data;
                default:        r_sched_len  <= r_sched_len;
            endcase
        end
    end

    // saturate task count at table depth
    assign count = (32'(r_task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                   : CNT_W'(r_task_count);

    assign item = '{cmd:              i_cmd,
                    task_index:       i_task_index,
                    release_time:     i_release_time,
                    exec_time:        i_exec_time,
                    period:           i_period,
                    initial_deadline: i_initial_deadline,
                    preemptible:      i_preemptible,
                    predecessor_mask: i_predecessor_mask};

    rmts_table #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rmts_seq #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (item),
        .i_count     (count),
        .i_sched_len (r_sched_len),
        .i_slot_free (!r_out_valid || i_ready),
        .o_push      (push),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // output register: hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_busy_res     = r_out.busy_res;
    assign o_running_task = r_out.running_task;
    assign o_job_done     = r_out.job_done;
    assign o_deadline_met = r_out.deadline_met;
    assign o_waiting_time = r_out.waiting_time;
    assign o_overrun      = r_out.overrun;
    assign o_past_end     = r_out.past_end;

endmodule

/* design/rmts_table.sv */
module rmts_table
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int IDX_W     = $clog2(MAX_TASKS)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [MAX_TASKS];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rmts_seq.sv */
module rmts_seq
    import rmts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int IDX_W     = $clog2(MAX_TASKS),
    parameter int CNT_W     = $clog2(MAX_TASKS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_item            i_item,
    input  logic [CNT_W-1:0] i_count,
    input  t_time            i_sched_len,
    input  logic             i_slot_free,
    output logic             o_push,
    output t_result          o_res,
    output logic             o_we,
    output logic [IDX_W-1:0] o_waddr,
    output t_entry           o_wdata,
    output logic [IDX_W-1:0] o_raddr,
    input  t_entry           i_rdata
);

    t_state                r_state, n_state;
    t_time                 r_time, n_time;
    logic [MAX_TASKS-1:0]  r_pending, n_pending;
    logic [MAX_TASKS-1:0]  r_spent, n_spent;
    logic                  r_run_valid, n_run_valid;
    logic [IDX_W-1:0]      r_run_idx, n_run_idx;
    logic                  r_run_nonpre, n_run_nonpre;
    logic [CNT_W-1:0]      r_issue, n_issue;
    logic                  r_pv, n_pv;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_pick, n_pick;
    t_time                 r_best, n_best;
    logic                  r_overrun, n_overrun;
    t_result               r_res, n_res;

    t_entry                e;
    logic [TIME_BITS:0]    sum;
    t_time                 nxt;
    logic [MAX_TASKS-1:0]  preds;
    logic [MAX_TASKS-1:0]  own;
    logic [TIME_BITS:0]    finish;
    logic signed [TIME_BITS+1:0] wt;
    logic                  keep;
    logic                  scan_end;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_pending   <= '0;
            r_spent     <= '0;
            r_run_valid <= 1'b0;
            r_run_idx   <= '0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_pending   <= n_pending;
            r_spent     <= n_spent;
            r_run_valid <= n_run_valid;
            r_run_idx   <= n_run_idx;
            r_pv        <= n_pv;
        end
    end

    // scan and result registers
    always_ff @(posedge i_clk) begin
        r_run_nonpre <= n_run_nonpre;
        r_issue      <= n_issue;
        r_pidx       <= n_pidx;
        r_found      <= n_found;
        r_pick       <= n_pick;
        r_best       <= n_best;
        r_overrun    <= n_overrun;
        r_res        <= n_res;
    end

    // next state, read-modify-write of the task table
    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_pending    = r_pending;
        n_spent      = r_spent;
        n_run_valid  = r_run_valid;
        n_run_idx    = r_run_idx;
        n_run_nonpre = r_run_nonpre;
        n_issue      = r_issue;
        n_pv         = r_pv;
        n_pidx       = r_pidx;
        n_found      = r_found;
        n_pick       = r_pick;
        n_best       = r_best;
        n_overrun    = r_overrun;
        n_res        = r_res;
        o_ready      = 1'b0;
        o_push       = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_pidx;
        e            = i_rdata;
        o_raddr      = r_issue[IDX_W-1:0];
        own          = MAX_TASKS'(1) << r_pidx;
        sum          = {1'b0, e.next_release} + {1'b0, e.period};
        nxt          = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        finish       = {1'b0, r_time} + (TIME_BITS+1)'(1);
        wt           = $signed({1'b0, finish}) - $signed({2'b00, e.job_release})
                       - $signed({2'b00, e.exec});
        scan_end     = !r_pv && (r_issue == i_count);
        keep         = r_run_valid && (CNT_W'(r_run_idx) < i_count)
                       && r_pending[r_run_idx] && r_run_nonpre;
        for (int j = 0; j < MAX_TASKS; j++) begin
            preds[j] = (j < 8) ? e.flags[j+1] : 1'b0;
        end
        preds = preds & ~own;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                o_we    = 1'b0;
                o_waddr = IDX_W'(i_item.task_index);
                o_wdata = '{next_release: i_item.release_time,
                            exec:         i_item.exec_time,
                            period:       i_item.period,
                            flags:        {i_item.predecessor_mask, i_item.preemptible},
                            deadline:     i_item.initial_deadline,
                            job_release:  '0,
                            remaining:    '0};
                if (i_valid) begin
                    if (i_item.cmd == CMD_LOAD) begin
                        if (32'(i_item.task_index) < MAX_TASKS) begin
                            o_we = 1'b1;
                            n_pending[o_waddr] = 1'b0;
                            n_spent[o_waddr]   = 1'b0;
                            if (r_run_valid && r_run_idx == o_waddr) begin
                                n_run_valid = 1'b0;
                            end
                        end
                    end else begin
                        n_res     = '0;
                        n_overrun = 1'b0;
                        if (r_time >= i_sched_len) begin
                            n_res.past_end = 1'b1;
                            n_state        = S_OUT;
                        end else begin
                            n_issue = '0;
                            n_pv    = 1'b0;
                            n_state = S_REL;
                        end
                    end
                end
            end

            S_REL: begin
                // release due jobs, one entry a cycle
                o_wdata = e;
                if (r_pv) begin
                    o_we = 1'b1;
                    if (e.next_release <= r_time && !r_spent[r_pidx]) begin
                        if (e.period == '0) begin
                            n_spent[r_pidx] = 1'b1;
                            if (r_pending[r_pidx]) begin
                                n_overrun = 1'b1;
                            end else begin
                                o_wdata.job_release = e.next_release;
                                o_wdata.remaining   = e.exec;
                                n_pending[r_pidx]   = 1'b1;
                            end
                        end else begin
                            o_wdata.next_release = nxt;
                            if (r_pending[r_pidx]) begin
                                n_overrun = 1'b1;
                            end else begin
                                o_wdata.job_release = e.next_release;
                                o_wdata.deadline    = nxt;
                                o_wdata.remaining   = e.exec;
                                n_pending[r_pidx]   = 1'b1;
                            end
                        end
                    end
                end
                if (r_issue < i_count) begin
                    n_issue = r_issue + CNT_W'(1);
                    n_pv    = 1'b1;
                    n_pidx  = r_issue[IDX_W-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (scan_end) begin
                    n_issue = '0;
                    n_found = keep;
                    n_pick  = r_run_idx;
                    n_state = keep ? S_RUN_RD : S_SEL;
                end
            end

            S_SEL: begin
                // pick shortest period among ready jobs
                o_wdata = e;
                if (r_pv && r_pending[r_pidx] && ((preds & r_pending) == '0)
                    && (!r_found || e.period < r_best)) begin
                    n_found = 1'b1;
                    n_pick  = r_pidx;
                    n_best  = e.period;
                end
                if (r_issue < i_count) begin
                    n_issue = r_issue + CNT_W'(1);
                    n_pv    = 1'b1;
                    n_pidx  = r_issue[IDX_W-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (scan_end) begin
                    n_state = S_RUN_RD;
                end
            end

            S_RUN_RD: begin
                o_wdata = e;
                o_raddr = r_pick;
                if (!r_found) begin
                    n_run_valid = 1'b0;
                    n_time      = finish[TIME_BITS-1:0];
                    n_state     = S_OUT;
                end else begin
                    n_state = S_RUN;
                end
            end

            S_RUN: begin
                // run picked job one unit and write it back
                o_we    = 1'b1;
                o_waddr = r_pick;
                o_wdata = e;
                n_res.busy_res     = 1'b1;
                n_res.running_task = 3'(r_pick);
                if (e.remaining <= t_time'(1)) begin
                    o_wdata.remaining  = '0;
                    n_pending[r_pick]  = 1'b0;
                    n_run_valid        = 1'b0;
                    n_res.job_done     = 1'b1;
                    n_res.deadline_met = (finish <= {1'b0, e.deadline});
                    if (wt < 0) begin
                        n_res.waiting_time = '0;
                    end else if (wt > (TIME_BITS+2)'(65535)) begin
                        n_res.waiting_time = '1;
                    end else begin
                        n_res.waiting_time = wt[WAIT_BITS-1:0];
                    end
                end else begin
                    o_wdata.remaining = e.remaining - t_time'(1);
                    n_run_valid       = 1'b1;
                    n_run_idx         = r_pick;
                    n_run_nonpre      = !e.flags[0];
                end
                n_time  = finish[TIME_BITS-1:0];
                n_state = S_OUT;
            end

            S_OUT: begin
                // hand result to the output register
                o_wdata = e;
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                o_wdata = e;
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res         = r_res;
        o_res.overrun = r_overrun;
    end

endmodule
